// ===== src/pee_pkg.sv =====
// Shared types, codes and helpers of the PCI enumeration engine.
package pee_pkg;

   // Scan and walk limits
   localparam int unsigned DEVICES_PER_BUS      = 32;
   localparam int unsigned FUNCTIONS_PER_DEVICE = 8;
   localparam int unsigned MAX_CAP_LINKS        = 64;

   // Input modes
   localparam logic [1:0] MODE_ID_SEARCH    = 2'd0;
   localparam logic [1:0] MODE_CLASS_SEARCH = 2'd1;
   localparam logic [1:0] MODE_CAP_WALK     = 2'd2;
   localparam logic [1:0] MODE_COMPLETION   = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_READ_REQ  = 2'd0;
   localparam logic [1:0] KIND_FINISHED  = 2'd1;
   localparam logic [1:0] KIND_IDLE_CPL  = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_VENDOR_ID      = 2'd0;
   localparam logic [1:0] CSR_DEVICE_ID_LOW  = 2'd1;
   localparam logic [1:0] CSR_DEVICE_ID_HIGH = 2'd2;
   localparam logic [1:0] CSR_CLASS_CODE     = 2'd3;

   // Config space dword offsets
   localparam logic [7:0] OFF_ID       = 8'h00;
   localparam logic [7:0] OFF_STATUS   = 8'h04;
   localparam logic [7:0] OFF_CLASS    = 8'h08;
   localparam logic [7:0] OFF_HEADER   = 8'h0C;
   localparam logic [7:0] OFF_CAP_HEAD = 8'h34;

   localparam logic [15:0] VENDOR_NONE = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ID,
      PH_CLASS,
      PH_HDR,
      PH_CSTAT,
      PH_CPTR,
      PH_CLINK
   } phase_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] read_data;
      logic [7:0]  match_index;
      logic [4:0]  target_device;
      logic [2:0]  target_function;
      logic [7:0]  capability_id;
      logic [7:0]  previous_offset;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address_word;
      logic        found;
      logic [4:0]  device_number;
      logic [2:0]  function_number;
      logic [15:0] found_vendor_id;
      logic [15:0] found_device_id;
      logic [7:0]  cap_offset;
   } rsp_item_type;

   // Config space read request on bus 0: enable bit, device, function, dword offset
   function automatic rsp_item_type make_req(logic [4:0] dev, logic [2:0] fn,
                                             logic [7:0] off);
      rsp_item_type r;
      r                 = '0;
      r.kind            = KIND_READ_REQ;
      r.address_word    = {1'b1, 15'd0, dev, fn, off[7:2], 2'b00};
      r.device_number   = dev;
      r.function_number = fn;
      return r;
   endfunction

   function automatic rsp_item_type make_miss();
      rsp_item_type r;
      r      = '0;
      r.kind = KIND_FINISHED;
      return r;
   endfunction

endpackage

// ===== src/pci_enumeration_engine_unit.sv =====
// Top level of the PCI bus 0 enumeration engine.
// Each accepted word passes through the input register and then the result register.
// Throughput: one word per cycle while the result register has room; each word is one
// pass through the sequencer logic between the input register and the result register.
// Reset (synchronous, active high) empties both registers, idles the sequencer and
// loads the config registers with their defaults.
module pci_enumeration_engine_unit
   import pee_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // read_data[31:0], match_index[39:32], target_device[44:40],
   // target_function[47:45], capability_id[55:48], previous_offset[63:56]
   input  logic [63:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // address_word[31:0], found[32], device_number[37:33], function_number[40:38],
   // found_vendor_id[56:41], found_device_id[72:57], cap_offset[80:73], zero[87:81]
   output logic [87:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_room, step;
   rsp_item_type step_rsp, out_rsp;

   // input register
   assign step        = in_valid_ff && out_room;
   assign req_tready  = !in_valid_ff || step;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.mode            <= req_tuser;
         in_item_ff.read_data       <= req_tdata[31:0];
         in_item_ff.match_index     <= req_tdata[39:32];
         in_item_ff.target_device   <= req_tdata[44:40];
         in_item_ff.target_function <= req_tdata[47:45];
         in_item_ff.capability_id   <= req_tdata[55:48];
         in_item_ff.previous_offset <= req_tdata[63:56];
      end
   end

   pee_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_en   (step),
      .item      (in_item_ff),
      .rsp       (step_rsp)
   );

   pee_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .load_data  (step_rsp),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .room       (out_room),
      .rsp_data   (out_rsp)
   );

   // result packing
   assign rsp_tuser = out_rsp.kind;
   assign rsp_tdata = {7'd0, out_rsp.cap_offset, out_rsp.found_device_id,
                       out_rsp.found_vendor_id, out_rsp.function_number,
                       out_rsp.device_number, out_rsp.found, out_rsp.address_word};

endmodule

// ===== src/pee_core.sv =====
// Enumeration sequencer: config registers, job state and one-step next logic.
module pee_core
   import pee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [23:0]  csr_wdata,
   input  logic         step_en,
   input  req_item_type item,
   output rsp_item_type rsp
);

   // Config registers
   logic [15:0] vendor_id_ff, device_id_low_ff, device_id_high_ff;
   logic [23:0] class_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_id_ff      <= '0;
         device_id_low_ff  <= '0;
         device_id_high_ff <= 16'hFFFF;
         class_code_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VENDOR_ID:      vendor_id_ff      <= csr_wdata[15:0];
            CSR_DEVICE_ID_LOW:  device_id_low_ff  <= csr_wdata[15:0];
            CSR_DEVICE_ID_HIGH: device_id_high_ff <= csr_wdata[15:0];
            CSR_CLASS_CODE:     class_code_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Job state
   phase_type   phase_ff, phase_in;
   logic [1:0]  search_kind_ff, search_kind_in;
   logic [4:0]  dev_ff, dev_in;
   logic [2:0]  fn_ff, fn_in;
   logic [7:0]  matches_left_ff, matches_left_in;
   logic [31:0] latched_ids_ff, latched_ids_in;
   logic [6:0]  link_ff, link_in;
   logic [7:0]  cap_ptr_ff, cap_ptr_in;
   logic [7:0]  cap_target_ff, cap_target_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         search_kind_ff  <= '0;
         dev_ff          <= '0;
         fn_ff           <= '0;
         matches_left_ff <= '0;
         latched_ids_ff  <= '0;
         link_ff         <= '0;
         cap_ptr_ff      <= '0;
         cap_target_ff   <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         search_kind_ff  <= search_kind_in;
         dev_ff          <= dev_in;
         fn_ff           <= fn_in;
         matches_left_ff <= matches_left_in;
         latched_ids_ff  <= latched_ids_in;
         link_ff         <= link_in;
         cap_ptr_ff      <= cap_ptr_in;
         cap_target_ff   <= cap_target_in;
      end
   end

   // Next state and result for one word
   logic [15:0] ven, did;
   logic        hit, go_fn, go_dev, go_follow, do_tally;
   logic [7:0]  ptr, ptr_off, ptr_byte;
   logic [3:0]  fn_next;
   logic [5:0]  dev_next;

   assign ven = item.read_data[15:0];
   assign did = item.read_data[31:16];
   assign ptr_off = (cap_ptr_ff == 8'd0) ? OFF_CAP_HEAD : cap_ptr_ff + 8'd1;
   assign fn_next  = {1'b0, fn_ff} + 4'd1;
   assign dev_next = {1'b0, dev_ff} + 6'd1;

   always_comb begin
      case (ptr_off[1:0])
         2'd0:    ptr_byte = item.read_data[7:0];
         2'd1:    ptr_byte = item.read_data[15:8];
         2'd2:    ptr_byte = item.read_data[23:16];
         default: ptr_byte = item.read_data[31:24];
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      search_kind_in  = search_kind_ff;
      dev_in          = dev_ff;
      fn_in           = fn_ff;
      matches_left_in = matches_left_ff;
      latched_ids_in  = latched_ids_ff;
      link_in         = link_ff;
      cap_ptr_in      = cap_ptr_ff;
      cap_target_in   = cap_target_ff;
      rsp             = '0;
      hit             = 1'b0;
      do_tally        = 1'b0;
      go_fn           = 1'b0;
      go_dev          = 1'b0;
      go_follow       = 1'b0;
      ptr             = '0;

      case (item.mode)
         MODE_ID_SEARCH, MODE_CLASS_SEARCH: begin
            search_kind_in  = item.mode;
            dev_in          = '0;
            fn_in           = '0;
            matches_left_in = item.match_index;
            latched_ids_in  = '0;
            phase_in        = PH_ID;
            rsp             = make_req(5'd0, 3'd0, OFF_ID);
         end
         MODE_CAP_WALK: begin
            search_kind_in = MODE_CAP_WALK;
            dev_in         = item.target_device;
            fn_in          = item.target_function;
            cap_target_in  = item.capability_id;
            cap_ptr_in     = item.previous_offset;
            link_in        = '0;
            phase_in       = PH_CSTAT;
            rsp            = make_req(item.target_device, item.target_function, OFF_STATUS);
         end
         default: begin
            case (phase_ff)
               PH_ID: begin
                  if (ven == VENDOR_NONE) begin
                     // empty slot on function 0 skips the whole device
                     if (fn_ff == 3'd0) go_dev = 1'b1;
                     else go_fn = 1'b1;
                  end else begin
                     latched_ids_in = item.read_data;
                     if (search_kind_ff == MODE_CLASS_SEARCH) begin
                        phase_in = PH_CLASS;
                        rsp      = make_req(dev_ff, fn_ff, OFF_CLASS);
                     end else begin
                        do_tally = 1'b1;
                        hit = (ven == vendor_id_ff) && (did >= device_id_low_ff) &&
                              (did <= device_id_high_ff);
                     end
                  end
               end
               PH_CLASS: begin
                  do_tally = 1'b1;
                  hit      = (item.read_data[31:8] == class_code_ff);
               end
               PH_HDR: begin
                  // header bit 7 clear: single-function device
                  if (!item.read_data[23]) go_dev = 1'b1;
                  else go_fn = 1'b1;
               end
               PH_CSTAT: begin
                  if (!item.read_data[20]) begin
                     phase_in = PH_IDLE;
                     rsp      = make_miss();
                  end else begin
                     phase_in = PH_CPTR;
                     rsp      = make_req(dev_ff, fn_ff, ptr_off);
                  end
               end
               PH_CPTR: begin
                  go_follow = 1'b1;
                  ptr       = ptr_byte;
               end
               PH_CLINK: begin
                  if (item.read_data[7:0] == cap_target_ff) begin
                     phase_in            = PH_IDLE;
                     rsp                 = make_miss();
                     rsp.found           = 1'b1;
                     rsp.device_number   = dev_ff;
                     rsp.function_number = fn_ff;
                     rsp.cap_offset      = cap_ptr_ff;
                  end else begin
                     link_in   = link_ff + 7'd1;
                     go_follow = 1'b1;
                     ptr       = item.read_data[15:8];
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  rsp      = '0;
                  rsp.kind = KIND_IDLE_CPL;
               end
            endcase
         end
      endcase

      // match counting, then header read on function 0
      if (do_tally) begin
         if (hit && matches_left_ff == 8'd0) begin
            phase_in            = PH_IDLE;
            rsp                 = make_miss();
            rsp.found           = 1'b1;
            rsp.device_number   = dev_ff;
            rsp.function_number = fn_ff;
            rsp.found_vendor_id = latched_ids_in[15:0];
            rsp.found_device_id = latched_ids_in[31:16];
         end else begin
            if (hit) matches_left_in = matches_left_ff - 8'd1;
            if (fn_ff == 3'd0) begin
               phase_in = PH_HDR;
               rsp      = make_req(dev_ff, fn_ff, OFF_HEADER);
            end else begin
               go_fn = 1'b1;
            end
         end
      end

      // advance function, falling through to the next device
      if (go_fn) begin
         if (fn_next >= 4'(FUNCTIONS_PER_DEVICE)) begin
            go_dev = 1'b1;
         end else begin
            fn_in    = fn_next[2:0];
            phase_in = PH_ID;
            rsp      = make_req(dev_ff, fn_next[2:0], OFF_ID);
         end
      end

      if (go_dev) begin
         if (dev_next >= 6'(DEVICES_PER_BUS)) begin
            phase_in = PH_IDLE;
            rsp      = make_miss();
         end else begin
            dev_in   = dev_next[4:0];
            fn_in    = '0;
            phase_in = PH_ID;
            rsp      = make_req(dev_next[4:0], 3'd0, OFF_ID);
         end
      end

      // capability link follow
      if (go_follow) begin
         if (ptr[7:2] == 6'd0 || link_in >= 7'(MAX_CAP_LINKS)) begin
            phase_in = PH_IDLE;
            rsp      = make_miss();
         end else begin
            cap_ptr_in = {ptr[7:2], 2'b00};
            phase_in   = PH_CLINK;
            rsp        = make_req(dev_ff, fn_ff, {ptr[7:2], 2'b00});
         end
      end
   end

endmodule

// ===== src/pee_out_reg.sv =====
// Result register with valid flag between the sequencer and the result channel.
module pee_out_reg
   import pee_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_data,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic         room,
   output rsp_item_type rsp_data
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   // free when empty or when the held word leaves this cycle
   assign room     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

// ===== src/pee_checker.sv =====
// Port-level checks of the enumeration engine and their binding to the top level.
module pee_checker
   import pee_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid after reset");

   // kind code three is never produced
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("illegal result kind");

   // a completion while idle carries all-zero fields
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_IDLE_CPL) |-> rsp_tdata == '0)
      else $error("idle completion with nonzero fields");

   // a read request has the enable bit and no match data
   a_req_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_READ_REQ) |->
         (rsp_tdata[31] && !rsp_tdata[32] && rsp_tdata[87:41] == '0))
      else $error("malformed read request");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

endmodule

bind pci_enumeration_engine_unit pee_checker u_pee_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
